[rtl/mcsm_pkg.sv]
// Shared types, constants and the symbol classifier for the melody contour matcher.
// No dependencies; every other file in rtl/ imports this package.
package mcsm_pkg;

    // Number of NFA states held in the active set (8..64).
    localparam int STATE_BITS = 64;

    localparam int SYM_W    = 7;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PLEN_W   = 6;

    // Command queue between front and back (power-of-two depth, pointers wrap).
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Result queue on the output side (power-of-two depth, pointers wrap).
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Contour alphabet.
    localparam logic [SYM_W-1:0] SYM_EQUAL = 7'h3D;
    localparam logic [SYM_W-1:0] SYM_UP    = 7'h2B;
    localparam logic [SYM_W-1:0] SYM_DOWN  = 7'h2D;
    localparam logic [SYM_W-1:0] SYM_SHARP = 7'h23;
    localparam logic [SYM_W-1:0] SYM_FLAT  = 7'h62;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STAY        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_EQUAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_UP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_DOWN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_SHARP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_FLAT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 3'd6;

    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_EQUAL = 3'd1,
        CLS_UP    = 3'd2,
        CLS_DOWN  = 3'd3,
        CLS_SHARP = 3'd4,
        CLS_FLAT  = 3'd5
    } t_sym_class;

    // One classified text beat.
    typedef struct packed {
        t_sym_class cls;
        logic       text_start;
        logic       text_end;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_res;

    // Pattern masks, trimmed to the state width.
    typedef struct packed {
        logic [STATE_BITS-1:0] stay;
        logic [STATE_BITS-1:0] adv_equal;
        logic [STATE_BITS-1:0] adv_up;
        logic [STATE_BITS-1:0] adv_down;
        logic [STATE_BITS-1:0] adv_sharp;
        logic [STATE_BITS-1:0] adv_flat;
        logic [PLEN_W-1:0]     pattern_length;
    } t_cfg;

    function automatic t_sym_class classify(input logic [SYM_W-1:0] sym);
        t_sym_class c;
        case (sym)
            SYM_EQUAL: c = CLS_EQUAL;
            SYM_UP:    c = CLS_UP;
            SYM_DOWN:  c = CLS_DOWN;
            SYM_SHARP: c = CLS_SHARP;
            SYM_FLAT:  c = CLS_FLAT;
            default:   c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

[rtl/melody_contour_shift_and_matcher_unit.sv]
// Melody contour shift-and matcher: a push beat accepted into the command queue is run by the
// back end straight from that queue; a result it yields goes to the result queue and its ports.
// Throughput one beat per cycle while the result queue has room; the NFA update is combinational.
// Reset (synchronous, active low) loads the register reset values, activates state zero,
// clears the position and done flag and empties both queues.
// Depends on mcsm_pkg, mcsm_front and mcsm_back.
module melody_contour_shift_and_matcher_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [mcsm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcsm_pkg::CFG_W-1:0]         i_cfg_data,
    // text input, queue-style
    input  logic                               push,
    output logic                               full,
    input  logic [mcsm_pkg::SYM_W-1:0]         i_symbol,
    input  logic                               i_text_start,
    input  logic                               i_text_end,
    // results, queue-style
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_found,
    output logic [mcsm_pkg::POS_W-1:0]         o_position
);
    import mcsm_pkg::*;

    // Pattern registers. Only the low STATE_BITS bits of each mask are kept;
    // the upper bits can never influence the active set.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stay           <= {{(STATE_BITS-1){1'b0}}, 1'b1};
            r_cfg.adv_equal      <= '0;
            r_cfg.adv_up         <= '0;
            r_cfg.adv_down       <= '0;
            r_cfg.adv_sharp      <= '0;
            r_cfg.adv_flat       <= '0;
            r_cfg.pattern_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STAY:        r_cfg.stay      <= i_cfg_data[STATE_BITS-1:0];
                CFG_ADV_EQUAL:   r_cfg.adv_equal <= i_cfg_data[STATE_BITS-1:0];
                CFG_ADV_UP:      r_cfg.adv_up    <= i_cfg_data[STATE_BITS-1:0];
                CFG_ADV_DOWN:    r_cfg.adv_down  <= i_cfg_data[STATE_BITS-1:0];
                CFG_ADV_SHARP:   r_cfg.adv_sharp <= i_cfg_data[STATE_BITS-1:0];
                CFG_ADV_FLAT:    r_cfg.adv_flat  <= i_cfg_data[STATE_BITS-1:0];
                CFG_PATTERN_LEN: r_cfg.pattern_length <= i_cfg_data[PLEN_W-1:0];
                default: ; // unmapped index: write is dropped
            endcase
        end
    end

    // Front <-> back command channel. The queue inside the front end lets
    // the input side keep taking beats while the back end waits on a full
    // result queue, and vice versa.
    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    mcsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_symbol     (i_symbol),
        .i_text_start (i_text_start),
        .i_text_end   (i_text_end),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_ready  (cmd_ready)
    );

    // Back end: one command per cycle into the NFA while the result queue has room; a match or
    // a text end without match drops one beat into the result queue.
    mcsm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_ready  (cmd_ready),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_found      (o_found),
        .o_position   (o_position)
    );

endmodule

[rtl/mcsm_front.sv]
// Front end: takes text beats, classifies the symbol and queues commands for the back end.
// Depends on mcsm_pkg.
module mcsm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [mcsm_pkg::SYM_W-1:0]    i_symbol,
    input  logic                          i_text_start,
    input  logic                          i_text_end,
    output logic                          o_cmd_valid,
    output mcsm_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_ready
);
    import mcsm_pkg::*;

    t_cmd                 r_queue [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count, n_count;
    logic                 wr_fire;
    logic                 rd_fire;
    t_cmd                 new_cmd;

    assign o_full      = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    assign wr_fire = i_push && !o_full;
    assign rd_fire = o_cmd_valid && i_cmd_ready;

    always_comb begin
        new_cmd.cls        = classify(i_symbol);
        new_cmd.text_start = i_text_start;
        new_cmd.text_end   = i_text_end;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr + (wr_fire ? CMD_PTR_W'(1) : CMD_PTR_W'(0));
        n_rd_ptr = r_rd_ptr + (rd_fire ? CMD_PTR_W'(1) : CMD_PTR_W'(0));
        n_count  = r_count;
        if (wr_fire && !rd_fire) begin
            n_count = r_count + CMD_CNT_W'(1);
        end else if (!wr_fire && rd_fire) begin
            n_count = r_count - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage, no reset
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_queue[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

[rtl/mcsm_back.sv]
// Back end: shift-and NFA update, match/no-match decision and the result queue.
// Depends on mcsm_pkg; takes commands from mcsm_front.
module mcsm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcsm_pkg::t_cfg                i_cfg,
    input  logic                          i_cmd_valid,
    input  mcsm_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_ready,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_found,
    output logic [mcsm_pkg::POS_W-1:0]    o_position
);
    import mcsm_pkg::*;

    logic [STATE_BITS-1:0] r_active, n_active;
    logic [POS_W-1:0]      r_index, n_index;
    logic                  r_done, n_done;

    t_res                  r_res [RES_DEPTH];
    logic [RES_PTR_W-1:0]  r_res_wr, r_res_rd;
    logic [RES_CNT_W-1:0]  r_res_count, n_res_count;

    logic                  run;
    logic                  live;
    logic                  produce;
    logic                  res_pop;
    logic                  hit;
    logic [STATE_BITS-1:0] cur_active;
    logic [POS_W-1:0]      cur_index;
    logic                  cur_done;
    logic [STATE_BITS-1:0] adv_sel;
    logic [STATE_BITS-1:0] step_set;
    logic [STATE_BITS-1:0] final_oh;
    t_res                  new_res;

    // any beat may yield a result, so only run with room in the result queue
    assign o_cmd_ready = (r_res_count != RES_CNT_W'(RES_DEPTH));
    assign run         = i_cmd_valid && o_cmd_ready;
    assign o_empty     = (r_res_count == '0);
    assign res_pop     = i_pop && !o_empty;
    assign o_found     = r_res[r_res_rd].found;
    assign o_position  = r_res[r_res_rd].position;

    always_comb begin
        case (i_cmd.cls)
            CLS_EQUAL: adv_sel = i_cfg.adv_equal;
            CLS_UP:    adv_sel = i_cfg.adv_up;
            CLS_DOWN:  adv_sel = i_cfg.adv_down;
            CLS_SHARP: adv_sel = i_cfg.adv_sharp;
            CLS_FLAT:  adv_sel = i_cfg.adv_flat;
            default:   adv_sel = '0;
        endcase
    end

    // final state beyond the top state shifts out and never matches
    assign final_oh = {{(STATE_BITS-1){1'b0}}, 1'b1} << i_cfg.pattern_length;

    always_comb begin
        if (i_cmd.text_start) begin
            cur_active = {{(STATE_BITS-1){1'b0}}, 1'b1};
            cur_index  = '0;
            cur_done   = 1'b0;
        end else begin
            cur_active = r_active;
            cur_index  = r_index;
            cur_done   = r_done;
        end

        step_set = ((cur_active & adv_sel) << 1) | (cur_active & i_cfg.stay);
        hit      = |(step_set & final_oh);
        live     = run && !cur_done;

        n_active = r_active;
        n_index  = r_index;
        n_done   = r_done;
        produce  = 1'b0;
        new_res.found    = 1'b0;
        new_res.position = '0;

        if (live) begin
            n_active = step_set;
            if (hit) begin
                n_index          = cur_index;
                n_done           = 1'b1;
                produce          = 1'b1;
                new_res.found    = 1'b1;
                new_res.position = cur_index;
            end else begin
                n_index = (cur_index == '1) ? cur_index : cur_index + POS_W'(1);
                n_done  = i_cmd.text_end;
                produce = i_cmd.text_end;
            end
        end else if (run && i_cmd.text_start) begin
            n_active = cur_active;
            n_index  = cur_index;
            n_done   = cur_done;
        end

        n_res_count = r_res_count;
        if (produce && !res_pop) begin
            n_res_count = r_res_count + RES_CNT_W'(1);
        end else if (!produce && res_pop) begin
            n_res_count = r_res_count - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= {{(STATE_BITS-1){1'b0}}, 1'b1};
            r_index     <= '0;
            r_done      <= 1'b0;
            r_res_wr    <= '0;
            r_res_rd    <= '0;
            r_res_count <= '0;
        end else begin
            r_active    <= n_active;
            r_index     <= n_index;
            r_done      <= n_done;
            r_res_count <= n_res_count;
            if (produce) begin
                r_res_wr <= r_res_wr + RES_PTR_W'(1);
            end
            if (res_pop) begin
                r_res_rd <= r_res_rd + RES_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_res[r_res_wr] <= new_res;
        end
    end

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_count <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> r_done)
        else $error("text not closed after a result");

    a_frozen_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(run && i_cmd.text_start)) |=> ($stable(r_active) && $stable(r_index)))
        else $error("state moved after text was closed");

    a_no_result_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && r_done && !i_cmd.text_start) |-> !produce)
        else $error("result from a closed text");

endmodule

[tb/sv/mcsm_tb_pkg.sv]
// Match-report scoreboard for the melody contour matcher testbench.
// Holds a shift-and predictor of the block and the queue of reports it expects.
// Depends on mcsm_pkg.
package mcsm_tb_pkg;
    import mcsm_pkg::*;

    localparam logic [CFG_W-1:0] LIVE_STATES =
        (STATE_BITS >= CFG_W) ? {CFG_W{1'b1}} : ((64'd1 << STATE_BITS) - 64'd1);

    class match_report_board;
        logic [CFG_W-1:0]  stay_bits;
        logic [CFG_W-1:0]  adv_equal;
        logic [CFG_W-1:0]  adv_up;
        logic [CFG_W-1:0]  adv_down;
        logic [CFG_W-1:0]  adv_sharp;
        logic [CFG_W-1:0]  adv_flat;
        logic [PLEN_W-1:0] goal_state;

        logic [CFG_W-1:0]  live_set;
        logic [POS_W-1:0]  sym_count;
        bit                text_closed;

        t_res              reports_due[$];
        int                errors;

        function new();
            stay_bits   = 64'd1;
            adv_equal   = '0;
            adv_up      = '0;
            adv_down    = '0;
            adv_sharp   = '0;
            adv_flat    = '0;
            goal_state  = '0;
            live_set    = 64'd1;
            sym_count   = '0;
            text_closed = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_STAY:        stay_bits  = data;
                CFG_ADV_EQUAL:   adv_equal  = data;
                CFG_ADV_UP:      adv_up     = data;
                CFG_ADV_DOWN:    adv_down   = data;
                CFG_ADV_SHARP:   adv_sharp  = data;
                CFG_ADV_FLAT:    adv_flat   = data;
                CFG_PATTERN_LEN: goal_state = data[PLEN_W-1:0];
                default: ;
            endcase
        endfunction

        // One accepted text beat: advance the active set, queue a report if one is due.
        function void take_text_beat(logic [SYM_W-1:0] sym, logic st, logic en);
            logic [CFG_W-1:0] adv;
            logic [CFG_W-1:0] cur;
            logic [CFG_W-1:0] goal_bit;
            t_res             rep;
            goal_bit = (64'd1 << goal_state) & LIVE_STATES;
            if (st) begin
                live_set    = 64'd1;
                sym_count   = '0;
                text_closed = 1'b0;
            end
            if (text_closed) return;
            case (sym)
                SYM_EQUAL: adv = adv_equal;
                SYM_UP:    adv = adv_up;
                SYM_DOWN:  adv = adv_down;
                SYM_SHARP: adv = adv_sharp;
                SYM_FLAT:  adv = adv_flat;
                default:   adv = '0;
            endcase
            cur      = live_set & LIVE_STATES;
            live_set = (((cur & adv) << 1) | (cur & stay_bits)) & LIVE_STATES;
            if ((live_set & goal_bit) != '0) begin
                rep.found    = 1'b1;
                rep.position = sym_count;
                reports_due  = {reports_due, rep};
                text_closed  = 1'b1;
                return;
            end
            if (sym_count != {POS_W{1'b1}}) sym_count++;
            if (en) begin
                rep.found    = 1'b0;
                rep.position = '0;
                reports_due  = {reports_due, rep};
                text_closed  = 1'b1;
            end
        endfunction

        function void check_report(logic found, logic [POS_W-1:0] pos);
            t_res want;
            if (reports_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected report, expected none, got found=%0b position=%0d",
                         $time, found, pos);
                return;
            end
            want = reports_due.pop_front();
            if (found !== want.found) begin
                errors++;
                $display("%0t: found mismatch, expected %0b, got %0b", $time, want.found, found);
            end
            if (pos !== want.position) begin
                errors++;
                $display("%0t: position mismatch, expected %0d, got %0d",
                         $time, want.position, pos);
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

endpackage

[tb/sv/tb.sv]
// Top-level testbench for melody_contour_shift_and_matcher_unit: drives contour texts and
// pattern masks, predicts every match report and checks it. Depends on mcsm_pkg, mcsm_tb_pkg.
module tb;
    import mcsm_pkg::*;
    import mcsm_tb_pkg::*;

    // Random beats per phase; eight phases plus the directed part give ~1850 beats.
    localparam int PHASE_BEATS    = 228;
    // Long receiver hold-off, enough to fill both internal queues and back up the input.
    localparam int HOLD_CYCLES    = 300;
    // Quiet cycles tolerated: the hold-off plus generous room for random gaps.
    localparam int WATCHDOG_LIMIT = 4000;
    // Settling wait before touching registers or finishing.
    localparam int SETTLE_CYCLES  = 8;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum {
        TOK_EQUAL, TOK_UP, TOK_DOWN, TOK_SHARP, TOK_FLAT, TOK_RISE, TOK_FALL, TOK_STAR
    } contour_tok_e;
    typedef enum {BRK_NONE, BRK_NO_START, BRK_NO_END, BRK_NOISE} text_break_e;
    typedef enum {
        PAT_SHORT, PAT_STARS, PAT_ANCHORED, PAT_LONG,
        MASK_FULL, MASK_ZERO, MASK_RANDOM, MASK_TOP
    } pattern_kind_e;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 push         = 1'b0;
    logic                 full;
    logic [SYM_W-1:0]     i_symbol     = '0;
    logic                 i_text_start = 1'b0;
    logic                 i_text_end   = 1'b0;
    logic                 empty;
    logic                 pop          = 1'b0;
    logic                 o_found;
    logic [POS_W-1:0]     o_position;

    match_report_board reports = new();

    // Idle/stall odds in percent, set per phase.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // Nonzero asks the receiver process for a hold-off of that many cycles.
    int rx_hold_req  = 0;
    int quiet_cycles = 0;

    // Register images for the next load, and the pattern they were compiled from.
    logic [CFG_W-1:0]  cfg_stay, cfg_equal, cfg_up, cfg_down, cfg_sharp, cfg_flat;
    logic [PLEN_W-1:0] cfg_plen;
    contour_tok_e      pat_tok[$];

    melody_contour_shift_and_matcher_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_symbol     (i_symbol),
        .i_text_start (i_text_start),
        .i_text_end   (i_text_end),
        .empty        (empty),
        .pop          (pop),
        .o_found      (o_found),
        .o_position   (o_position)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: every popped beat is checked against the oldest expected report.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) reports.check_report(o_found, o_position);
    end

    // Watchdog: any beat moving on either side restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("tb failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted here when requested.
    initial begin
        int hold_n;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                hold_n      = rx_hold_req;
                rx_hold_req = 0;
                pop <= 1'b0;
                repeat (hold_n - 1) @(negedge i_clk);
            end else begin
                pop <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Contour symbol most of the time, any 7-bit character otherwise.
    function automatic logic [SYM_W-1:0] text_symbol();
        if ($urandom_range(99) < 20) return SYM_W'($urandom_range(127));
        case ($urandom_range(4))
            0:       return SYM_EQUAL;
            1:       return SYM_UP;
            2:       return SYM_DOWN;
            3:       return SYM_SHARP;
            default: return SYM_FLAT;
        endcase
    endfunction

    // A text symbol that satisfies one pattern token ('^' and '_' pick either member).
    function automatic logic [SYM_W-1:0] token_symbol(contour_tok_e tok);
        case (tok)
            TOK_EQUAL: return SYM_EQUAL;
            TOK_UP:    return SYM_UP;
            TOK_DOWN:  return SYM_DOWN;
            TOK_SHARP: return SYM_SHARP;
            TOK_FLAT:  return SYM_FLAT;
            TOK_RISE:  return $urandom_range(1) ? SYM_UP : SYM_SHARP;
            TOK_FALL:  return $urandom_range(1) ? SYM_DOWN : SYM_FLAT;
            default:   return text_symbol();
        endcase
    endfunction

    // Offer one beat (after a random idle gap) and hold it until the block takes it.
    // Entered and left at a falling edge.
    task automatic send_beat(input logic [SYM_W-1:0] sym, input logic st, input logic en);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            push         <= 1'b0;
            i_symbol     <= SYM_W'($urandom_range(127));
            i_text_start <= 1'($urandom_range(1));
            i_text_end   <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_symbol     <= sym;
        i_text_start <= st;
        i_text_end   <= en;
        while (!taken) begin
            @(posedge i_clk);
            if (!full) begin
                taken = 1'b1;
                reports.take_text_beat(sym, st, en);
            end
            @(negedge i_clk);
        end
    endtask

    // Write enable stays high across back-to-back writes; load_config lowers it.
    task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        reports.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Registers change only with the block idle: all reports in, last beat settled.
    task automatic load_config();
        logic [CFG_W-1:0] plen_word;
        while (reports.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        // junk above the 6-bit field must be dropped by the block
        plen_word = {$urandom(), $urandom()};
        plen_word[PLEN_W-1:0] = cfg_plen;
        write_cfg_reg(CFG_STAY,        cfg_stay);
        write_cfg_reg(CFG_ADV_EQUAL,   cfg_equal);
        write_cfg_reg(CFG_ADV_UP,      cfg_up);
        write_cfg_reg(CFG_ADV_DOWN,    cfg_down);
        write_cfg_reg(CFG_ADV_SHARP,   cfg_sharp);
        write_cfg_reg(CFG_ADV_FLAT,    cfg_flat);
        write_cfg_reg(CFG_PATTERN_LEN, plen_word);
        i_cfg_we <= 1'b0;
    endtask

    task automatic clear_masks();
        pat_tok.delete();
        cfg_stay  = '0;
        cfg_equal = '0;
        cfg_up    = '0;
        cfg_down  = '0;
        cfg_sharp = '0;
        cfg_flat  = '0;
        cfg_plen  = '0;
    endtask

    // Random contour pattern, compiled the way software would: one state per symbol
    // token, '^'/'_' set two masks, '*' makes the current state stay.
    task automatic build_pattern(input int n_sym, input bit anchored, input bit stars);
        int st;
        clear_masks();
        for (int k = 0; k < n_sym; k++) begin
            if (stars && $urandom_range(99) < 25) pat_tok = {pat_tok, TOK_STAR};
            pat_tok = {pat_tok, contour_tok_e'($urandom_range(TOK_FALL))};
        end
        // unanchored search keeps state zero alive on every symbol
        cfg_stay[0] = !anchored;
        st = 0;
        foreach (pat_tok[k]) begin
            case (pat_tok[k])
                TOK_STAR:  cfg_stay[st]  = 1'b1;
                TOK_EQUAL: cfg_equal[st] = 1'b1;
                TOK_UP:    cfg_up[st]    = 1'b1;
                TOK_DOWN:  cfg_down[st]  = 1'b1;
                TOK_SHARP: cfg_sharp[st] = 1'b1;
                TOK_FLAT:  cfg_flat[st]  = 1'b1;
                TOK_RISE: begin
                    cfg_up[st]    = 1'b1;
                    cfg_sharp[st] = 1'b1;
                end
                TOK_FALL: begin
                    cfg_down[st] = 1'b1;
                    cfg_flat[st] = 1'b1;
                end
                default: ;
            endcase
            if (pat_tok[k] != TOK_STAR) st++;
        end
        cfg_plen = PLEN_W'(st);
    endtask

    // One text: random symbols, optionally with the pattern planted somewhere.
    // A few texts are broken: no start, no end, or random flags on every beat.
    task automatic send_text(input int max_len, input bit plant, inout int sent);
        logic [SYM_W-1:0] txt[$];
        logic [SYM_W-1:0] motif[$];
        text_break_e      brk;
        int               len;
        int               at;
        logic             st;
        logic             en;
        len = $urandom_range(max_len, 1);
        for (int k = 0; k < len; k++) txt = {txt, text_symbol()};
        if (plant) begin
            foreach (pat_tok[k]) begin
                if (pat_tok[k] == TOK_STAR) begin
                    repeat ($urandom_range(3)) motif = {motif, text_symbol()};
                end else begin
                    motif = {motif, token_symbol(pat_tok[k])};
                end
            end
            while (txt.size() < motif.size()) txt = {txt, text_symbol()};
            at = $urandom_range(txt.size() - motif.size());
            foreach (motif[k]) txt[at + k] = motif[k];
        end
        brk = BRK_NONE;
        if ($urandom_range(99) < 8) brk = text_break_e'($urandom_range(BRK_NOISE, BRK_NO_START));
        foreach (txt[k]) begin
            st = (k == 0) && (brk != BRK_NO_START);
            en = (k == txt.size() - 1) && (brk != BRK_NO_END);
            if (brk == BRK_NOISE) begin
                st = ($urandom_range(9) == 0);
                en = ($urandom_range(9) == 0);
            end
            send_beat(txt[k], st, en);
            sent++;
        end
    endtask

    task automatic directed_checks();
        // Reset values: state zero stays and is also the goal, so the first beat
        // matches even without a text start; the rest of that text is ignored.
        send_beat(SYM_EQUAL, 1'b0, 1'b0);
        send_beat(SYM_UP,    1'b0, 1'b0);
        send_beat(SYM_UP,    1'b0, 1'b1);
        send_beat(SYM_EQUAL, 1'b1, 1'b1);
        push <= 1'b0;

        // Pattern "=+"; the '-' mask only has the top bit, which shifts out.
        clear_masks();
        cfg_stay     = 64'd1;
        cfg_equal[0] = 1'b1;
        cfg_up[1]    = 1'b1;
        cfg_down     = 64'h8000_0000_0000_0000;
        cfg_plen     = PLEN_W'(2);
        load_config();
        send_beat(SYM_EQUAL, 1'b1, 1'b0);
        send_beat(SYM_UP,    1'b0, 1'b0);             // match at 1
        send_beat(SYM_EQUAL, 1'b0, 1'b0);             // ignored after a match
        send_beat(SYM_DOWN,  1'b0, 1'b1);
        send_beat(SYM_W'(0),     1'b1, 1'b0);         // other symbols, both extremes
        send_beat({SYM_W{1'b1}}, 1'b0, 1'b0);
        send_beat(SYM_SHARP, 1'b0, 1'b0);
        send_beat(SYM_FLAT,  1'b0, 1'b1);             // no-match report
        send_beat(SYM_DOWN,  1'b1, 1'b0);
        send_beat(SYM_EQUAL, 1'b0, 1'b0);
        send_beat(SYM_UP,    1'b0, 1'b1);             // match on the last symbol only
        send_beat(SYM_EQUAL, 1'b1, 1'b1);             // one-symbol text, no match
        push <= 1'b0;

        // Pattern "^_" plus an all-ones '=' mask.
        clear_masks();
        cfg_stay     = 64'd1;
        cfg_up[0]    = 1'b1;
        cfg_sharp[0] = 1'b1;
        cfg_down[1]  = 1'b1;
        cfg_flat[1]  = 1'b1;
        cfg_equal    = {CFG_W{1'b1}};
        cfg_plen     = PLEN_W'(2);
        load_config();
        send_beat(SYM_SHARP, 1'b1, 1'b0);
        send_beat(SYM_FLAT,  1'b0, 1'b0);
        send_beat(SYM_UP,    1'b1, 1'b0);
        send_beat(SYM_DOWN,  1'b0, 1'b1);
        send_beat(SYM_EQUAL, 1'b1, 1'b0);
        send_beat(SYM_EQUAL, 1'b0, 1'b1);
        push <= 1'b0;
    endtask

    task automatic run_phase(input pattern_kind_e kind, input idle_mode_e idle,
                             input int max_len, input bit squeeze);
        int sent;
        case (kind)
            PAT_SHORT:    build_pattern($urandom_range(3, 1), 1'b0, 1'b0);
            PAT_STARS:    build_pattern($urandom_range(6, 3), 1'b0, 1'b1);
            PAT_ANCHORED: build_pattern($urandom_range(4, 1), 1'b1, 1'b0);
            PAT_LONG:     build_pattern($urandom_range(40, 20), 1'b0, 1'b1);
            MASK_FULL: begin
                clear_masks();
                cfg_stay  = {CFG_W{1'b1}};
                cfg_equal = {CFG_W{1'b1}};
                cfg_up    = {CFG_W{1'b1}};
                cfg_down  = {CFG_W{1'b1}};
                cfg_sharp = {CFG_W{1'b1}};
                cfg_flat  = {CFG_W{1'b1}};
                cfg_plen  = {PLEN_W{1'b1}};
            end
            MASK_ZERO: clear_masks();
            MASK_RANDOM: begin
                clear_masks();
                cfg_stay    = {$urandom(), $urandom()};
                cfg_stay[0] = ($urandom_range(3) != 0);
                cfg_equal   = {$urandom(), $urandom()};
                cfg_up      = {$urandom(), $urandom()};
                cfg_down    = {$urandom(), $urandom()};
                cfg_sharp   = {$urandom(), $urandom()};
                cfg_flat    = {$urandom(), $urandom()};
                cfg_plen    = PLEN_W'($urandom_range(8, 1));
            end
            default: begin
                // every symbol advances every state: a growing run whose top bits fall off
                clear_masks();
                cfg_stay  = 64'd1;
                cfg_equal = {CFG_W{1'b1}};
                cfg_up    = {CFG_W{1'b1}};
                cfg_down  = {CFG_W{1'b1}};
                cfg_sharp = {CFG_W{1'b1}};
                cfg_flat  = {CFG_W{1'b1}};
                cfg_plen  = PLEN_W'($urandom_range(63, 50));
            end
        endcase
        load_config();
        tx_idle_pct  = (idle == IDLE_SENDER)   ? 70 : (idle == IDLE_BOTH) ? 27 : 0;
        rx_stall_pct = (idle == IDLE_RECEIVER) ? 70 : (idle == IDLE_BOTH) ? 27 : 0;
        if (squeeze) rx_hold_req = HOLD_CYCLES;
        sent = 0;
        while (sent < PHASE_BEATS) send_text(max_len, 1'($urandom_range(1)), sent);
        push <= 1'b0;
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_checks();

        run_phase(PAT_SHORT,    IDLE_NONE,     12, 1'b1);
        run_phase(PAT_STARS,    IDLE_SENDER,   16, 1'b0);
        run_phase(MASK_RANDOM,  IDLE_RECEIVER, 10, 1'b0);
        run_phase(PAT_ANCHORED, IDLE_BOTH,     12, 1'b0);
        run_phase(MASK_FULL,    IDLE_NONE,     80, 1'b0);
        run_phase(MASK_ZERO,    IDLE_RECEIVER,  8, 1'b0);
        run_phase(PAT_LONG,     IDLE_BOTH,     60, 1'b0);
        run_phase(MASK_TOP,     IDLE_SENDER,   80, 1'b0);

        // drain, then give stray extra reports a chance to show up
        while (reports.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (reports.errors == 0 && reports.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
